@@ src/ula_pkg.sv @@
// shared types and constants for the serial line assembler
package ula_pkg;

  localparam int unsigned BUF_SIZE_DEF   = 64;
  localparam int unsigned Q_DEPTH        = 2;
  localparam logic [7:0]  NEWLINE_CHAR   = 8'h0A;
  localparam logic [15:0] TIMEOUT_MS_RST = 16'd100;

  typedef enum logic [1:0] {
    FUNC_RX_BYTE   = 2'd0,
    FUNC_TAKE_LINE = 2'd1,
    FUNC_READ_BYTE = 2'd2
  } func_t;

  typedef enum logic {
    CFG_TIMEOUT_ENABLE = 1'b0,
    CFG_TIMEOUT_MS     = 1'b1
  } cfg_idx_t;

  // operation class worked out at the front
  typedef enum logic [2:0] {
    OP_DATA,
    OP_NEWLINE,
    OP_TAKE,
    OP_READ,
    OP_NONE
  } op_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
    logic [5:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic       line_ready;
    logic       overflow;
    logic [6:0] line_length;
    logic [7:0] read_data;
  } out_item_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
    logic [5:0]  read_index;
  } q_entry_t;

  typedef struct packed {
    logic        valid;
    cfg_idx_t    index;
    logic [15:0] data;
  } cfg_wr_t;

endpackage

@@ src/ula_ram.sv @@
// generic single write port, single read port ram with registered read
module ula_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/ula_front.sv @@
// front end: accepts transactions, classifies them and queues them for the back end
module ula_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ula_pkg::in_item_t in_data,
  output logic              q_valid,
  output ula_pkg::q_entry_t q_entry,
  input  logic              q_pop
);
  import ula_pkg::*;

  localparam int unsigned QPW = $clog2(Q_DEPTH);
  localparam int unsigned QCW = $clog2(Q_DEPTH + 1);

  q_entry_t       q_mem_r [Q_DEPTH];
  logic [QPW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;
  logic           push;
  q_entry_t       cls;

  // classify
  always_comb begin
    cls.rx_byte    = in_data.rx_byte;
    cls.now_ms     = in_data.now_ms;
    cls.read_index = in_data.read_index;
    unique case (func_t'(in_data.func))
      FUNC_RX_BYTE:   cls.op = (in_data.rx_byte == NEWLINE_CHAR) ? OP_NEWLINE : OP_DATA;
      FUNC_TAKE_LINE: cls.op = OP_TAKE;
      FUNC_READ_BYTE: cls.op = OP_READ;
      default:        cls.op = OP_NONE;
    endcase
  end

  assign in_stall = (count_r == QCW'(Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_entry  = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + QPW'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + QPW'(1) : rd_ptr_r;
    count_nxt  = count_r + QCW'(push) - QCW'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

@@ src/ula_back.sv @@
// back end: line buffer state, timeout check, store access and result register
module ula_back #(
  parameter int unsigned BUF_SIZE = ula_pkg::BUF_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ula_pkg::cfg_wr_t   cfg,
  input  logic               q_valid,
  input  ula_pkg::q_entry_t  q_entry,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output ula_pkg::out_item_t out_data
);
  import ula_pkg::*;

  localparam int unsigned IDXW  = $clog2(BUF_SIZE);
  localparam int unsigned FCW   = $clog2(BUF_SIZE + 1);
  localparam int unsigned AW    = IDXW + 1;
  localparam int unsigned DEPTH = 2 * (2 ** IDXW);

  logic           ten_r;
  logic [15:0]    tms_r;
  logic [FCW-1:0] fill_r [2];
  logic [FCW-1:0] fill_nxt [2];
  logic           active_r, active_nxt;
  logic           fin_buf_r, fin_buf_nxt;
  logic           ready_r, ready_nxt;
  logic           ovr_r, ovr_nxt;
  logic [FCW-1:0] fin_len_r, fin_len_nxt;
  logic [31:0]    dl_r, dl_nxt;

  logic           fire;
  logic           timed_out;
  logic [31:0]    dl_sum;
  logic [FCW-1:0] fill_cur;
  logic [FCW-1:0] fill_inc;
  logic           has_room;
  logic           rd_in_range;
  logic [6:0]     len_res;

  logic           wr_en, rd_en;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic [7:0]     rd_data;

  logic           out_valid_r;
  logic           rdy_res_r, ovr_res_r, rd_sel_r;
  logic [6:0]     len_res_r;

  assign fire  = q_valid && (!out_valid_r || !out_stall);
  assign q_pop = fire;

  assign timed_out = ten_r && (dl_r != '0) && (q_entry.now_ms >= dl_r);
  assign dl_sum    = q_entry.now_ms + {16'b0, tms_r};
  assign fill_cur  = timed_out ? '0 : fill_r[active_r];
  assign has_room  = fill_cur < FCW'(BUF_SIZE);
  assign fill_inc  = fill_cur + FCW'(1);

  // read offset must fall inside both the finished line and the buffer
  assign rd_in_range = (32'(q_entry.read_index) < 32'(fin_len_r)) &&
                       (32'(q_entry.read_index) < 32'(BUF_SIZE));

  assign wr_addr = {active_r, fill_cur[IDXW-1:0]};
  assign rd_addr = {fin_buf_r, IDXW'(q_entry.read_index)};

  always_comb begin
    fill_nxt    = fill_r;
    active_nxt  = active_r;
    fin_buf_nxt = fin_buf_r;
    ready_nxt   = ready_r;
    ovr_nxt     = ovr_r;
    fin_len_nxt = fin_len_r;
    dl_nxt      = dl_r;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    if (fire) begin
      unique case (q_entry.op)
        OP_DATA, OP_NEWLINE: begin
          if (ten_r) begin
            if (timed_out) begin
              ovr_nxt = 1'b1;
            end
            dl_nxt = (dl_sum == '0) ? 32'd1 : dl_sum;
          end
          if (has_room) begin
            wr_en            = 1'b1;
            fill_nxt[active_r] = fill_inc;
            if (q_entry.op == OP_NEWLINE) begin
              ready_nxt           = 1'b1;
              fin_len_nxt         = fill_inc;
              fin_buf_nxt         = active_r;
              active_nxt          = ~active_r;
              fill_nxt[~active_r] = '0;
              if (ten_r) begin
                dl_nxt = '0;
              end
            end
          end else begin
            ovr_nxt            = 1'b1;
            fill_nxt[active_r] = '0;
            if (ten_r) begin
              dl_nxt = '0;
            end
          end
        end
        OP_TAKE: begin
          ready_nxt = 1'b0;
          ovr_nxt   = 1'b0;
        end
        OP_READ: begin
          rd_en = rd_in_range;
        end
        default: begin
        end
      endcase
    end
    if (q_entry.op == OP_TAKE && ovr_r) begin
      len_res = '0;
    end else begin
      len_res = 7'(fin_len_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ten_r     <= 1'b0;
      tms_r     <= TIMEOUT_MS_RST;
      fill_r[0] <= '0;
      fill_r[1] <= '0;
      active_r  <= 1'b0;
      fin_buf_r <= 1'b0;
      ready_r   <= 1'b0;
      ovr_r     <= 1'b0;
      fin_len_r <= '0;
      dl_r      <= '0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_TIMEOUT_ENABLE: ten_r <= cfg.data[0];
          CFG_TIMEOUT_MS:     tms_r <= cfg.data;
          default: begin
          end
        endcase
      end
      fill_r    <= fill_nxt;
      active_r  <= active_nxt;
      fin_buf_r <= fin_buf_nxt;
      ready_r   <= ready_nxt;
      ovr_r     <= ovr_nxt;
      fin_len_r <= fin_len_nxt;
      dl_r      <= dl_nxt;
    end
  end

  ula_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (q_entry.rx_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // result register; store read data lands alongside it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fire || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rdy_res_r <= ready_nxt;
      ovr_res_r <= ovr_nxt;
      len_res_r <= len_res;
      rd_sel_r  <= rd_en;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_data.line_ready  = rdy_res_r;
  assign out_data.overflow    = ovr_res_r;
  assign out_data.line_length = len_res_r;
  assign out_data.read_data   = rd_sel_r ? rd_data : 8'h00;

endmodule

@@ src/uart_line_assembler_unit.sv @@
// top level of the serial line assembler with ping-pong line buffers
//
//  channel | ports                        | moves
//  --------+------------------------------+-------------------------------------
//  in      | in_valid, in_stall, in_data  | one access: byte, take line or read
//  out     | out_valid, out_stall, out_data | one result per accepted access
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write, always ready
//
// one transaction per cycle while in_stall is low; a result passes through a front queue
// entry and then the back end result register before it leaves on the out channel
// while a result waits on out_stall the two-entry queue takes up to two more
// transactions, then in_stall stays high until the back end frees an entry
// reset is synchronous; the line store needs no clearing pass, only read once written
module uart_line_assembler_unit #(
  parameter int unsigned BUF_SIZE = ula_pkg::BUF_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ula_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ula_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  ula_pkg::cfg_idx_t  cfg_index,
  input  logic [15:0]        cfg_data
);
  import ula_pkg::*;

  logic     q_valid;
  logic     q_pop;
  q_entry_t q_entry;
  cfg_wr_t  cfg;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid && cfg_ready;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  ula_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop)
  );

  ula_back #(
    .BUF_SIZE (BUF_SIZE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ tb/uart_line_assembler_unit_tb.sv @@
// self-checking testbench for the serial line assembler with ping-pong line buffers
module uart_line_assembler_unit_tb;
  import ula_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // line predictor and store of expected results, in transaction order
  class line_scoreboard;
    bit [7:0]    line_mem [2*BUF_SIZE_DEF];
    int unsigned fill [2];
    bit          active_sel;
    bit          done_sel;
    bit          ready;
    bit          overrun;
    int unsigned done_len;
    bit [31:0]   deadline;
    bit          tmo_en;
    bit [15:0]   tmo_ms;
    out_item_t   expected_q [$];
    int          errors;

    function new();
      tmo_ms = TIMEOUT_MS_RST;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    function void set_reg(cfg_idx_t idx, logic [15:0] val);
      case (idx)
        CFG_TIMEOUT_ENABLE: tmo_en = val[0];
        CFG_TIMEOUT_MS:     tmo_ms = val;
        default: ;
      endcase
    endfunction

    function void note_input(in_item_t it);
      out_item_t   res;
      bit          a;
      int unsigned len;
      res = '0;
      len = done_len;
      case (it.func)
        FUNC_RX_BYTE: begin
          a = active_sel;
          if (tmo_en) begin
            if (deadline != 0 && it.now_ms >= deadline) begin
              overrun = 1'b1;
              fill[a] = 0;
            end
            deadline = it.now_ms + {16'd0, tmo_ms};
            // zero is reserved for no deadline
            if (deadline == 0) deadline = 32'd1;
          end
          if (fill[a] < BUF_SIZE_DEF) begin
            line_mem[{a, fill[a][5:0]}] = it.rx_byte;
            fill[a]++;
            if (it.rx_byte == NEWLINE_CHAR) begin
              ready      = 1'b1;
              done_len   = fill[a];
              done_sel   = a;
              active_sel = !a;
              fill[!a]   = 0;
              if (tmo_en) deadline = '0;
            end
          end else begin
            // byte lost, partial line dropped
            overrun = 1'b1;
            fill[a] = 0;
            if (tmo_en) deadline = '0;
          end
          len = done_len;
        end
        FUNC_TAKE_LINE: begin
          if (overrun) len = 0;
          overrun = 1'b0;
          ready   = 1'b0;
        end
        FUNC_READ_BYTE: begin
          if (it.read_index < done_len) res.read_data = line_mem[{done_sel, it.read_index}];
        end
        default: ;
      endcase
      res.line_ready  = ready;
      res.overflow    = overrun;
      res.line_length = len[6:0];
      expected_q.push_back(res);
    endfunction

    task check_result(out_item_t got);
      out_item_t exp;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
        return;
      end
      exp = expected_q.pop_front();
      if (got.line_ready !== exp.line_ready)
        report_mismatch($sformatf("line_ready got %b want %b", got.line_ready, exp.line_ready));
      if (got.overflow !== exp.overflow)
        report_mismatch($sformatf("overflow got %b want %b", got.overflow, exp.overflow));
      if (got.line_length !== exp.line_length)
        report_mismatch($sformatf("line_length got %0d want %0d",
                                  got.line_length, exp.line_length));
      if (got.read_data !== exp.read_data)
        report_mismatch($sformatf("read_data got %h want %h", got.read_data, exp.read_data));
    endtask
  endclass

  bit          clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_idx_t    cfg_index;
  logic [15:0] cfg_data;

  line_scoreboard sb;
  bit             idle_on = 1'b1;
  int             hold_reqs = 0;
  int             n_sent = 0;
  logic [31:0]    clock_ms = '0;

  uart_line_assembler_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // all three channels observed at the rising edge, inputs noted before results
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // receiver: random stalls, plus a long hold-off whenever one is requested
  initial begin
    int hold_seen;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        out_stall = 1'b1;
        repeat (80) @(negedge clk);
      end
      out_stall = idle_on && ($urandom_range(0, 99) < 7);
    end
  end

  initial begin
    #400000;
    $display("uart_line_assembler_unit test failed");
    $finish;
  end

  function automatic in_item_t mk_item(logic [1:0] f, logic [7:0] b, logic [31:0] t,
                                       logic [5:0] idx);
    in_item_t it;
    it.func       = f;
    it.rx_byte    = b;
    it.now_ms     = t;
    it.read_index = idx;
    return it;
  endfunction

  function automatic logic [31:0] next_stamp(int unsigned gap_max);
    if ($urandom_range(0, 99) < 3) clock_ms = $urandom();
    else clock_ms += $urandom_range(0, gap_max);
    return clock_ms;
  endfunction

  task automatic send(in_item_t it);
    if (idle_on && $urandom_range(0, 99) < 7) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // one line of random content, then mostly a take and a few reads, now and then noise
  task automatic gen_line(int unsigned gap_max);
    int          len;
    int          roll;
    logic [7:0]  b;
    logic [5:0]  idx;
    roll = $urandom_range(0, 99);
    if (roll < 65) len = $urandom_range(0, 10);
    else if (roll < 88) len = $urandom_range(11, 62);
    else len = $urandom_range(63, 66);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == NEWLINE_CHAR && $urandom_range(0, 9) != 0) b = b + 8'd1;
      send(mk_item(FUNC_RX_BYTE, b, next_stamp(gap_max), 6'($urandom())));
    end
    send(mk_item(FUNC_RX_BYTE, NEWLINE_CHAR, next_stamp(gap_max), 6'($urandom())));
    if ($urandom_range(0, 99) < 80)
      send(mk_item(FUNC_TAKE_LINE, 8'($urandom()), $urandom(), 6'($urandom())));
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 99) < 80) idx = 6'($urandom_range(0, (len < 63) ? len : 63));
      else idx = 6'($urandom_range(0, 63));
      send(mk_item(FUNC_READ_BYTE, 8'($urandom()), $urandom(), idx));
    end
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 3))
        send(mk_item(2'($urandom_range(0, 3)), 8'($urandom()), $urandom(),
                     6'($urandom())));
    end
  endtask

  task automatic run_phase(int budget, int unsigned gap_max);
    int start;
    start = n_sent;
    while (n_sent - start < budget) gen_line(gap_max);
  endtask

  initial begin
    int unsigned pick;
    sb        = new();
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_TIMEOUT_ENABLE;
    cfg_data  = '0;
    rst_n     = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // take and read with nothing ready, unused code, field extremes
    send(mk_item(FUNC_TAKE_LINE, 8'h00, 32'h0, 6'd0));
    send(mk_item(FUNC_READ_BYTE, 8'h00, 32'h0, 6'd63));
    send(mk_item(FUNC_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63));
    send(mk_item(FUNC_RX_BYTE, 8'hFF, 32'h0, 6'd63));
    send(mk_item(FUNC_RX_BYTE, 8'h00, 32'hFFFF_FFFF, 6'd0));
    send(mk_item(FUNC_RX_BYTE, NEWLINE_CHAR, 32'h10, 6'd0));
    for (int i = 0; i < 4; i++) send(mk_item(FUNC_READ_BYTE, 8'h00, 32'h0, 6'(i)));
    // second line replaces the untaken first one
    send(mk_item(FUNC_RX_BYTE, 8'h41, 32'h20, 6'd0));
    send(mk_item(FUNC_RX_BYTE, NEWLINE_CHAR, 32'h30, 6'd0));
    send(mk_item(FUNC_READ_BYTE, 8'h00, 32'h0, 6'd0));
    send(mk_item(FUNC_READ_BYTE, 8'h00, 32'h0, 6'd1));
    send(mk_item(FUNC_TAKE_LINE, 8'h00, 32'h0, 6'd0));
    send(mk_item(FUNC_TAKE_LINE, 8'h00, 32'h0, 6'd0));
    send(mk_item(FUNC_UNUSED, 8'h00, 32'h0, 6'd0));

    // timeout off, upper data bits ignored; receiver holds off early on
    drain();
    write_reg(CFG_TIMEOUT_ENABLE, 16'hFFFE);
    hold_reqs++;
    run_phase(150, 1000);

    drain();
    write_reg(CFG_TIMEOUT_MS, 16'd0);
    write_reg(CFG_TIMEOUT_ENABLE, 16'd1);
    run_phase(100, 4);

    drain();
    write_reg(CFG_TIMEOUT_MS, 16'hFFFF);
    // deadline sum wraps to zero here
    clock_ms = 32'hFFFF_0001;
    send(mk_item(FUNC_RX_BYTE, 8'h55, clock_ms, 6'd0));
    run_phase(150, 70000);

    drain();
    pick = $urandom_range(10, 40);
    write_reg(CFG_TIMEOUT_MS, pick[15:0]);
    idle_on = 1'b0;
    run_phase(150, pick * 5 / 4);
    idle_on = 1'b1;
    // partial line, so a deadline survives the disabled period
    repeat (3) send(mk_item(FUNC_RX_BYTE, 8'h61, next_stamp(pick / 2), 6'($urandom())));

    drain();
    pick = $urandom();
    write_reg(CFG_TIMEOUT_ENABLE, {pick[14:0], 1'b0});
    write_reg(CFG_TIMEOUT_MS, pick[31:16]);
    run_phase(120, 500);

    drain();
    write_reg(CFG_TIMEOUT_MS, 16'd50);
    write_reg(CFG_TIMEOUT_ENABLE, 16'd1);
    run_phase(130, 60);

    drain();
    repeat (8) @(negedge clk);
    if (sb.errors == 0) begin
      $display("uart_line_assembler_unit test passed");
    end else begin
      $display("uart_line_assembler_unit test failed");
    end
    $finish;
  end

endmodule
